>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files; capsule_surface_clamp.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: label, clock, active-low reset, property, message.
`define CSC_ASSERT_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Short form for modules clocked by aclk and reset by aresetn.
`define CSC_ASSERT(lbl, prop, msg) `CSC_ASSERT_ON(lbl, aclk, aresetn, prop, msg)

`endif

>>> hw/rtl/csc_pkg.sv
`default_nettype none
package csc_pkg;

    localparam int SqSteps  = 33;
    localparam int DivSteps = 34;
    localparam int CfgIdxW  = 3;

    localparam logic [CfgIdxW-1:0] CFG_AXIS_X = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_AXIS_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_AXIS_Z = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_LENGTH = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TUBE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_SLACK  = 3'd5;

    typedef struct packed {
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic [30:0]        axis_len;
        logic [30:0]        tube;
        logic [30:0]        slack;
    } cfg_t;

    // Nearest axis point and original centre.
    typedef struct packed {
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic signed [32:0] cz;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    // Sideband that rides along with the square root.
    typedef struct packed {
        pos_t             pos;
        logic [2:0]       sneg;
        logic [2:0][62:0] prod;
        logic             viol;
        logic             zero;
    } side_t;

    // Sideband that rides along with the dividers.
    typedef struct packed {
        pos_t        pos;
        logic [2:0]  sneg;
        logic        viol;
        logic        zero;
        logic [32:0] root_dist;
    } dside_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               moved;
        logic               violation;
        logic               degenerate;
        logic [30:0]        axis_distance;
        logic signed [31:0] tip_distance;
    } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/csc_geom.sv
`default_nettype none
module csc_geom (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] cell_x,
    input  wire logic signed [31:0] cell_y,
    input  wire logic signed [31:0] cell_z,
    input  wire logic [30:0]        cell_radius,
    input  wire csc_pkg::cfg_t      cfg,
    output logic                    out_valid,
    output logic [65:0]             rad,
    output csc_pkg::side_t          side
);

    typedef struct packed {
        csc_pkg::pos_t    pos;
        logic [2:0][31:0] dmag;
        logic [2:0]       dneg;
        logic [31:0]      mmag;
        logic             mneg;
        logic [30:0]      kmag;
        logic             kneg;
    } g1_t;

    typedef struct packed {
        csc_pkg::pos_t    pos;
        logic [2:0][63:0] sq;
        logic [2:0][62:0] prod;
        logic [2:0]       sneg;
        logic [63:0]      mm;
        logic             mneg;
    } g2_t;

    g1_t g1_next, g1_reg;
    g2_t g2_next, g2_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic [65:0] rad_next, rad_reg;
    csc_pkg::side_t side_next, side_reg;

    logic signed [32:0] x33, start33, end33, cx33, cy33, cz33, dy33, dz33, dyn, dzn, m33;
    logic signed [33:0] dx34, dxn;
    logic signed [31:0] k32, kn;

    // First stage: nearest point on the segment, the difference vector and the margins.
    always_comb begin
        x33     = {cell_x[31], cell_x};
        start33 = {cfg.axis_x[31], cfg.axis_x};
        end33   = start33 + {2'b00, cfg.axis_len};
        if (x33 <= start33) begin
            cx33 = start33;
        end else if (x33 >= end33) begin
            cx33 = end33;
        end else begin
            cx33 = x33;
        end
        cy33 = {cfg.axis_y[31], cfg.axis_y};
        cz33 = {cfg.axis_z[31], cfg.axis_z};
        dx34 = {x33[32], x33} - {cx33[32], cx33};
        dxn  = -dx34;
        dy33 = {cell_y[31], cell_y} - cy33;
        dyn  = -dy33;
        dz33 = {cell_z[31], cell_z} - cz33;
        dzn  = -dz33;
        m33  = {2'b00, cfg.tube} + {2'b00, cfg.slack} - {2'b00, cell_radius};
        k32  = {1'b0, cfg.tube} - {1'b0, cell_radius};
        kn   = -k32;

        g1_next.pos.cx   = cx33;
        g1_next.pos.cy   = cy33;
        g1_next.pos.cz   = cz33;
        g1_next.pos.x    = cell_x;
        g1_next.pos.y    = cell_y;
        g1_next.pos.z    = cell_z;
        g1_next.dmag[0]  = dx34[33] ? dxn[31:0] : dx34[31:0];
        g1_next.dmag[1]  = dy33[32] ? dyn[31:0] : dy33[31:0];
        g1_next.dmag[2]  = dz33[32] ? dzn[31:0] : dz33[31:0];
        g1_next.dneg     = {dz33[32], dy33[32], dx34[33]};
        g1_next.mmag     = m33[31:0];
        g1_next.mneg     = m33[32];
        g1_next.kmag     = k32[31] ? kn[30:0] : k32[30:0];
        g1_next.kneg     = k32[31];
    end

    // Second stage: the squares, the squared limit and the move products.
    always_comb begin
        g2_next.pos  = g1_reg.pos;
        g2_next.mneg = g1_reg.mneg;
        g2_next.mm   = 64'(g1_reg.mmag) * 64'(g1_reg.mmag);
        for (int l = 0; l < 3; l++) begin
            g2_next.sq[l]   = 64'(g1_reg.dmag[l]) * 64'(g1_reg.dmag[l]);
            g2_next.prod[l] = 63'(g1_reg.kmag) * 63'(g1_reg.dmag[l]);
            g2_next.sneg[l] = g1_reg.kneg ^ g1_reg.dneg[l];
        end
    end

    // Third stage: squared distance and the violation test.
    always_comb begin
        rad_next = 66'(g2_reg.sq[0]) + 66'(g2_reg.sq[1]) + 66'(g2_reg.sq[2]);
        side_next.pos  = g2_reg.pos;
        side_next.sneg = g2_reg.sneg;
        side_next.prod = g2_reg.prod;
        side_next.viol = g2_reg.mneg || (rad_next > 66'(g2_reg.mm));
        side_next.zero = (rad_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg   <= g1_next;
            g2_reg   <= g2_next;
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v3_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;

endmodule
`default_nettype wire

>>> hw/rtl/csc_sqrt.sv
`default_nettype none
module csc_sqrt (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [65:0]    rad_i,
    input  wire csc_pkg::side_t side_i,
    output logic                out_valid,
    output logic [32:0]         root,
    output csc_pkg::side_t      side_o
);

    localparam int Steps = csc_pkg::SqSteps;

    logic           valid_reg [Steps];
    logic [65:0]    rad_reg   [Steps];
    logic [34:0]    rem_reg   [Steps];
    logic [32:0]    root_reg  [Steps];
    csc_pkg::side_t side_reg  [Steps];

    // One result bit per stage: two radicand bits enter the partial remainder.
    for (genvar i = 0; i < Steps; i++) begin : g_step
        logic           v_in;
        logic [65:0]    rad_in;
        logic [34:0]    rem_in;
        logic [32:0]    root_in;
        csc_pkg::side_t side_in;
        logic [35:0]    rem_sh, trial, rem_diff;
        logic           ge;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = rad_i;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = side_i;
        end else begin : g_rest
            assign v_in    = valid_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign rem_sh   = {rem_in[33:0], rad_in[65:64]};
        assign trial    = {1'b0, root_in, 2'b01};
        assign ge       = (rem_sh >= trial);
        assign rem_diff = rem_sh - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i]  <= {rad_in[63:0], 2'b00};
                rem_reg[i]  <= ge ? rem_diff[34:0] : rem_sh[34:0];
                root_reg[i] <= {root_in[31:0], ge};
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[Steps-1];
    assign root      = root_reg[Steps-1];
    assign side_o    = side_reg[Steps-1];

endmodule
`default_nettype wire

>>> hw/rtl/csc_div.sv
`default_nettype none
module csc_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [32:0]    root_dist,
    input  wire csc_pkg::side_t side_i,
    output logic                out_valid,
    output logic [2:0][33:0]    quo,
    output logic [2:0]          ovf,
    output csc_pkg::dside_t     dside_o
);

    localparam int Steps = csc_pkg::DivSteps;

    // Prepare stage: add half the divisor for rounding, flag quotients that
    // would not fit in the quotient width (those saturate downstream anyway).
    logic                  p_valid_reg;
    logic [2:0][66:0]      p_rem_next, p_rem_reg;
    logic [2:0]            p_ovf_next, p_ovf_reg;
    csc_pkg::dside_t       p_ds_next, p_ds_reg;
    logic [63:0]           divd;

    always_comb begin
        p_ds_next.pos       = side_i.pos;
        p_ds_next.sneg      = side_i.sneg;
        p_ds_next.viol      = side_i.viol;
        p_ds_next.zero      = side_i.zero;
        p_ds_next.root_dist = root_dist;
        for (int l = 0; l < 3; l++) begin
            divd          = {1'b0, side_i.prod[l]} + {32'b0, root_dist[32:1]};
            p_rem_next[l] = {3'b000, divd};
            p_ovf_next[l] = (p_rem_next[l] >= {root_dist, 34'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_rem_reg <= p_rem_next;
            p_ovf_reg <= p_ovf_next;
            p_ds_reg  <= p_ds_next;
        end
    end

    logic             st_valid_reg [Steps];
    logic [2:0][66:0] st_rem_reg   [Steps];
    logic [2:0][33:0] st_q_reg     [Steps];
    logic [2:0]       st_ovf_reg   [Steps];
    csc_pkg::dside_t  st_ds_reg    [Steps];

    // Restoring division, one quotient bit per stage, three lanes side by side.
    for (genvar j = 0; j < Steps; j++) begin : g_step
        localparam int B = Steps - 1 - j;
        logic             v_in;
        logic [2:0][66:0] rem_in;
        logic [2:0][33:0] q_in;
        logic [2:0]       ovf_in;
        csc_pkg::dside_t  ds_in;
        logic [66:0]      dsh;
        logic [2:0][66:0] rem_nx;
        logic [2:0][33:0] q_nx;
        logic             ge;

        if (j == 0) begin : g_first
            assign v_in   = p_valid_reg;
            assign rem_in = p_rem_reg;
            assign q_in   = '0;
            assign ovf_in = p_ovf_reg;
            assign ds_in  = p_ds_reg;
        end else begin : g_rest
            assign v_in   = st_valid_reg[j-1];
            assign rem_in = st_rem_reg[j-1];
            assign q_in   = st_q_reg[j-1];
            assign ovf_in = st_ovf_reg[j-1];
            assign ds_in  = st_ds_reg[j-1];
        end

        assign dsh = {34'b0, ds_in.root_dist} << B;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                ge        = (rem_in[l] >= dsh);
                rem_nx[l] = ge ? (rem_in[l] - dsh) : rem_in[l];
                q_nx[l]   = {q_in[l][32:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_valid_reg[j] <= 1'b0;
            end else if (en) begin
                st_valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_rem_reg[j] <= rem_nx;
                st_q_reg[j]   <= q_nx;
                st_ovf_reg[j] <= ovf_in;
                st_ds_reg[j]  <= ds_in;
            end
        end
    end

    assign out_valid = st_valid_reg[Steps-1];
    assign quo       = st_q_reg[Steps-1];
    assign ovf       = st_ovf_reg[Steps-1];
    assign dside_o   = st_ds_reg[Steps-1];

endmodule
`default_nettype wire

>>> hw/rtl/csc_out.sv
`default_nettype none
module csc_out (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [2:0][33:0] quo,
    input  wire logic [2:0]      ovf,
    input  wire csc_pkg::dside_t dside,
    input  wire csc_pkg::cfg_t   cfg,
    output logic                 out_valid,
    output csc_pkg::res_t        res
);

    // A value fits in 32 signed bits when its top six bits all agree.
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if ((&v[36:31]) || !(|v[36:31])) begin
            r = v[31:0];
        end else begin
            r = v[36] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return r;
    endfunction

    logic                    f1_valid_reg, f2_valid_reg;
    csc_pkg::res_t           f1_next, f1_reg, f2_next, f2_reg;
    logic [2:0][32:0]        cpt;
    logic [2:0][31:0]        orig;
    logic [2:0][31:0]        npt;
    logic [34:0]             qe;
    logic signed [35:0]      sv;
    logic signed [36:0]      sum, tip;
    logic                    moved;

    always_comb begin
        cpt  = {dside.pos.cz, dside.pos.cy, dside.pos.cx};
        orig = {dside.pos.z, dside.pos.y, dside.pos.x};
        moved = dside.viol && !dside.zero;
        for (int l = 0; l < 3; l++) begin
            qe  = ovf[l] ? {1'b1, 34'b0} : {1'b0, quo[l]};
            sv  = dside.sneg[l] ? -$signed({1'b0, qe}) : $signed({1'b0, qe});
            sum = $signed({{4{cpt[l][32]}}, cpt[l]}) + $signed({sv[35], sv});
            npt[l] = moved ? sat32(sum) : orig[l];
        end
        f1_next.new_x         = npt[0];
        f1_next.new_y         = npt[1];
        f1_next.new_z         = npt[2];
        f1_next.moved         = moved;
        f1_next.violation     = dside.viol;
        f1_next.degenerate    = dside.viol && dside.zero;
        f1_next.axis_distance = (|dside.root_dist[32:31]) ? '1 : dside.root_dist[30:0];
        f1_next.tip_distance  = '0;
    end

    always_comb begin
        f2_next = f1_reg;
        tip = $signed({6'b0, cfg.axis_len}) + $signed({6'b0, cfg.tube})
            - $signed({{5{f1_reg.new_x[31]}}, f1_reg.new_x});
        f2_next.tip_distance = sat32(tip);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
        end
    end

    assign out_valid = f2_valid_reg;
    assign res       = f2_reg;

endmodule
`default_nettype wire

>>> hw/rtl/capsule_surface_clamp.sv
// An accepted request passes the geometry, square-root, divider and output stages to the m_ channel.
// Throughput: one request per cycle while m_ready does not hold the pipeline; set by the
// three 35-stage divider lanes, all fully pipelined.
// A result that waits on m_ready holds every stage, and s_ready drops with it.
// Reset: synchronous, active-low aresetn clears all valid bits and loads
// the register defaults (axis start 0, length, tube and slack 1.0).
`default_nettype none
`include "assert_macros.svh"
module capsule_surface_clamp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_cell_x,
    input  wire logic signed [31:0] s_cell_y,
    input  wire logic signed [31:0] s_cell_z,
    input  wire logic [30:0]        s_cell_radius,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_new_x,
    output logic signed [31:0]      m_new_y,
    output logic signed [31:0]      m_new_z,
    output logic                    m_moved,
    output logic                    m_violation,
    output logic                    m_degenerate,
    output logic [30:0]             m_axis_distance,
    output logic signed [31:0]      m_tip_distance
);

    csc_pkg::cfg_t   cfg_reg;
    logic            en;
    logic            geo_valid, sq_valid;
    logic [65:0]     rad;
    csc_pkg::side_t  geo_side, sq_side;
    logic [32:0]     root;
    logic            div_valid;
    logic [2:0][33:0] quo;
    logic [2:0]      ovf;
    csc_pkg::dside_t dside;
    csc_pkg::res_t   res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_x   <= '0;
            cfg_reg.axis_y   <= '0;
            cfg_reg.axis_z   <= '0;
            cfg_reg.axis_len <= 31'd65536;
            cfg_reg.tube     <= 31'd65536;
            cfg_reg.slack    <= 31'd65536;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                csc_pkg::CFG_AXIS_X: cfg_reg.axis_x   <= cfg_data;
                csc_pkg::CFG_AXIS_Y: cfg_reg.axis_y   <= cfg_data;
                csc_pkg::CFG_AXIS_Z: cfg_reg.axis_z   <= cfg_data;
                csc_pkg::CFG_LENGTH: cfg_reg.axis_len <= cfg_data[30:0];
                csc_pkg::CFG_TUBE:   cfg_reg.tube     <= cfg_data[30:0];
                csc_pkg::CFG_SLACK:  cfg_reg.slack    <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together unless a result sits unclaimed.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    csc_geom u_geom (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .cell_x      (s_cell_x),
        .cell_y      (s_cell_y),
        .cell_z      (s_cell_z),
        .cell_radius (s_cell_radius),
        .cfg         (cfg_reg),
        .out_valid   (geo_valid),
        .rad         (rad),
        .side        (geo_side)
    );

    csc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (geo_valid),
        .rad_i     (rad),
        .side_i    (geo_side),
        .out_valid (sq_valid),
        .root      (root),
        .side_o    (sq_side)
    );

    csc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .root_dist (root),
        .side_i    (sq_side),
        .out_valid (div_valid),
        .quo       (quo),
        .ovf       (ovf),
        .dside_o   (dside)
    );

    csc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .quo       (quo),
        .ovf       (ovf),
        .dside     (dside),
        .cfg       (cfg_reg),
        .out_valid (m_valid),
        .res       (res)
    );

    assign m_new_x         = res.new_x;
    assign m_new_y         = res.new_y;
    assign m_new_z         = res.new_z;
    assign m_moved         = res.moved;
    assign m_violation     = res.violation;
    assign m_degenerate    = res.degenerate;
    assign m_axis_distance = res.axis_distance;
    assign m_tip_distance  = res.tip_distance;

    `CSC_ASSERT(a_moved_needs_viol, m_valid && m_moved |-> m_violation, "move without violation")
    `CSC_ASSERT(a_degen_needs_viol, m_valid && m_degenerate |-> m_violation, "degenerate flag without violation")
    `CSC_ASSERT(a_moved_not_degen, m_valid |-> !(m_moved && m_degenerate), "moved and degenerate together")
    `CSC_ASSERT(a_degen_zero_dist, m_valid && m_degenerate |-> m_axis_distance == '0, "degenerate with nonzero distance")

endmodule
`default_nettype wire

>>> dv/capsule_surface_clamp_checker.sv
`timescale 1ns / 1ps
module capsule_surface_clamp_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic signed [31:0] s_cell_x,
    input  wire logic signed [31:0] s_cell_y,
    input  wire logic signed [31:0] s_cell_z,
    input  wire logic [30:0]        s_cell_radius,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [31:0] m_new_x,
    input  wire logic signed [31:0] m_new_y,
    input  wire logic signed [31:0] m_new_z,
    input  wire logic               m_moved,
    input  wire logic               m_violation,
    input  wire logic               m_degenerate,
    input  wire logic [30:0]        m_axis_distance,
    input  wire logic signed [31:0] m_tip_distance,
    output int                      fail_count,
    output int                      pending
);

    csc_pkg::cfg_t shadow_cfg;
    csc_pkg::res_t expected_centres[$];

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rounded division, halves away from zero; 64-bit unsigned like the hardware spec.
    function automatic longint pull_back(longint k, longint d, logic [63:0] den);
        logic [63:0] q;
        q = (magnitude(k) * magnitude(d) + den / 2) / den;
        return ((k < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic csc_pkg::res_t clamp_predict(logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z,
                                                    logic [30:0] rad);
        longint        ax, ay, az, len, tube, slack, px, rr, ex, cx, dx, dy, dz, m, k;
        longint        nx, ny, nz;
        logic [127:0]  norm, t2, mm;
        logic [63:0]   root, t;
        logic          viol, zero;
        csc_pkg::res_t r;
        ax = longint'(shadow_cfg.axis_x);
        ay = longint'(shadow_cfg.axis_y);
        az = longint'(shadow_cfg.axis_z);
        len = longint'(shadow_cfg.axis_len);
        tube = longint'(shadow_cfg.tube);
        slack = longint'(shadow_cfg.slack);
        px = longint'(x);
        rr = longint'(rad);
        ex = ax + len;
        if (px <= ax) cx = ax;
        else if (px >= ex) cx = ex;
        else cx = px;
        dx = px - cx;
        dy = longint'(y) - ay;
        dz = longint'(z) - az;
        norm = 128'(magnitude(dx)) * 128'(magnitude(dx))
             + 128'(magnitude(dy)) * 128'(magnitude(dy))
             + 128'(magnitude(dz)) * 128'(magnitude(dz));
        root = '0;
        for (int b = 35; b >= 0; b--) begin
            t = root | (64'd1 << b);
            t2 = 128'(t) * 128'(t);
            if (t2 <= norm) root = t;
        end
        zero = (norm == '0);
        m = tube + slack - rr;
        mm = (m < 0) ? '0 : 128'(m) * 128'(m);
        viol = (m < 0) || (norm > mm);
        nx = px;
        ny = longint'(y);
        nz = longint'(z);
        if (viol && !zero) begin
            k = tube - rr;
            nx = sat32(cx + pull_back(k, dx, root));
            ny = sat32(ay + pull_back(k, dy, root));
            nz = sat32(az + pull_back(k, dz, root));
        end
        r.new_x = nx[31:0];
        r.new_y = ny[31:0];
        r.new_z = nz[31:0];
        r.moved = viol && !zero;
        r.violation = viol;
        r.degenerate = viol && zero;
        r.axis_distance = (root > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : root[30:0];
        r.tip_distance = 32'(sat32(len + tube - nx));
        return r;
    endfunction

    always @(posedge aclk) begin
        csc_pkg::res_t got, want;
        if (!aresetn) begin
            shadow_cfg <= '{axis_x: '0, axis_y: '0, axis_z: '0,
                            axis_len: 31'd65536, tube: 31'd65536, slack: 31'd65536};
            expected_centres.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    csc_pkg::CFG_AXIS_X: shadow_cfg.axis_x <= cfg_data;
                    csc_pkg::CFG_AXIS_Y: shadow_cfg.axis_y <= cfg_data;
                    csc_pkg::CFG_AXIS_Z: shadow_cfg.axis_z <= cfg_data;
                    csc_pkg::CFG_LENGTH: shadow_cfg.axis_len <= cfg_data[30:0];
                    csc_pkg::CFG_TUBE:   shadow_cfg.tube <= cfg_data[30:0];
                    csc_pkg::CFG_SLACK:  shadow_cfg.slack <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_centres.push_back(clamp_predict(s_cell_x, s_cell_y, s_cell_z,
                                                         s_cell_radius));
            if (m_valid && m_ready) begin
                got = '{m_new_x, m_new_y, m_new_z, m_moved, m_violation, m_degenerate,
                        m_axis_distance, m_tip_distance};
                if (expected_centres.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected request result %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_centres.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_centres.size();
        end
    end

endmodule

>>> dv/capsule_surface_clamp_tb.sv
`timescale 1ns / 1ps
module capsule_surface_clamp_tb;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam logic [2:0] CFG_LAST   = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_cell_x = '0, s_cell_y = '0, s_cell_z = '0;
    logic [30:0]        s_cell_radius = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_new_x, m_new_y, m_new_z, m_tip_distance;
    logic               m_moved, m_violation, m_degenerate;
    logic [30:0]        m_axis_distance;
    int                 fail_count, pending;
    int                 tx_idle, rx_idle;
    longint             cur_ax, cur_ay, cur_az, cur_len, cur_tube, cur_slack;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    capsule_surface_clamp u_dut (.*);
    capsule_surface_clamp_checker u_checker (.*);

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= rx_idle);

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_cell(longint x, longint y, longint z, longint rad);
        logic hs;
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cell_x <= x[31:0];
        s_cell_y <= y[31:0];
        s_cell_z <= z[31:0];
        s_cell_radius <= rad[30:0];
        forever begin
            @(negedge aclk);
            hs = s_ready;
            @(posedge aclk);
            if (hs) break;
        end
    endtask

    // Holds the sender off until every request has come back and the pipe is empty.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Leaves the write enable high; set_capsule drops it after its last write.
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            csc_pkg::CFG_AXIS_X: cur_ax = longint'($signed(val));
            csc_pkg::CFG_AXIS_Y: cur_ay = longint'($signed(val));
            csc_pkg::CFG_AXIS_Z: cur_az = longint'($signed(val));
            csc_pkg::CFG_LENGTH: cur_len = longint'(val[30:0]);
            csc_pkg::CFG_TUBE:   cur_tube = longint'(val[30:0]);
            csc_pkg::CFG_SLACK:  cur_slack = longint'(val[30:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_capsule(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                               logic [31:0] len, logic [31:0] tube, logic [31:0] slack);
        cfg_write(csc_pkg::CFG_AXIS_X, ax);
        cfg_write(csc_pkg::CFG_AXIS_Y, ay);
        cfg_write(csc_pkg::CFG_AXIS_Z, az);
        cfg_write(csc_pkg::CFG_LENGTH, len);
        cfg_write(csc_pkg::CFG_TUBE, tube);
        cfg_write(csc_pkg::CFG_SLACK, slack);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic longint around(longint c, longint span);
        longint sp;
        sp = (span > 64'sd1000000000) ? 64'sd1000000000 : span + 1;
        return c + longint'($urandom_range(2 * sp)) - sp;
    endfunction

    task automatic random_cells(int count);
        longint reach, rad;
        for (int i = 0; i < count; i++) begin
            if (i == count / 3) begin
                tx_idle = 62;
                rx_idle = 13;
            end else if (i == 2 * count / 3) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            reach = cur_tube + cur_slack;
            rad = longint'($urandom_range(reach > 1000000000 ? 1000000000 : reach));
            case ($urandom_range(9))
                0: send_cell($urandom, $urandom, $urandom, $urandom & 32'h7FFF_FFFF);
                // Centre on the axis line: zero distance within the segment, degenerate when the radius is large.
                1: send_cell(around(cur_ax + cur_len / 2, cur_len), cur_ay, cur_az,
                             $urandom_range(1) ? rad : reach + rad);
                default: send_cell(around(cur_ax + cur_len / 2, cur_len),
                                   around(cur_ay, reach + rad), around(cur_az, reach + rad),
                                   rad);
            endcase
        end
    endtask

    initial begin
        tx_idle = 13;
        rx_idle = 62;
        cur_ax = 0; cur_ay = 0; cur_az = 0;
        cur_len = 65536; cur_tube = 65536; cur_slack = 65536;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cells under the reset capsule.
        send_cell(32'sh0000_8000, 0, 0, 0);                // inside, no violation
        send_cell(32'sh0000_8000, 0, 0, 32'h3_0000);       // on axis, degenerate
        send_cell(-32'sh0001_0000, 32'h3_0000, 0, 0);      // before the start
        send_cell(32'sh0003_0000, 0, 32'h3_0000, 0);       // beyond the end
        send_cell(32'sh0000_8000, 32'h4_0000, 32'h4_0000, 32'h2_0000); // radius > tube
        send_cell(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        send_cell(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
        send_cell(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_cell(0, 0, 0, 0);                             // exactly at the start
        send_cell(32'h1_0000, 32'h2_0000, 0, 0);           // exactly at the end, on the rim
        send_cell(32'h0_8000, 32'h0_0001, 0, 31'h7FFF_FFFF);
        drain();

        cfg_write(CFG_UNUSED, $urandom);
        cfg_write(CFG_LAST, $urandom);
        set_capsule(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cell(32'sh8000_0000, 0, 32'sh8000_0000, 0);
        send_cell(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_cell(0, 32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF);
        random_cells(150);
        drain();

        set_capsule(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1);
        random_cells(200);
        drain();

        set_capsule(0, 0, 0, 0, 0, 0);
        send_cell(0, 0, 0, 0);
        send_cell(32'h1, 32'h1, 32'h1, 31'h1);
        random_cells(150);
        drain();

        for (int s = 0; s < 4; s++) begin
            tx_idle = 13;
            rx_idle = 62;
            set_capsule($urandom_range(32'h0100_0000), $urandom, $urandom_range(32'h40_0000),
                        $urandom_range(32'h20_0000, 1), $urandom_range(32'h8_0000, 1),
                        $urandom_range(32'h2_0000, 1));
            random_cells(270);
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/csc_pkg.sv
hw/rtl/csc_geom.sv
hw/rtl/csc_sqrt.sv
hw/rtl/csc_div.sv
hw/rtl/csc_out.sv
hw/rtl/capsule_surface_clamp.sv
dv/capsule_surface_clamp_checker.sv
dv/capsule_surface_clamp_tb.sv
